### rtl/sha_pkg.sv
// Shared types, constants and helper functions for the SHA-256 stream hasher.
// No dependencies; imported by every module of the block.
package sha_pkg;

  typedef logic [31:0] word_t;
  typedef logic [7:0][31:0] hash_t;

  localparam int unsigned RoundCount = 64;
  localparam int unsigned BlockBytes = 64;
  localparam logic [5:0] LenPos = 6'd56;
  localparam logic [5:0] LastPos = 6'd63;
  localparam logic [5:0] LastRound = 6'd63;
  localparam logic [5:0] SchedStart = 6'd16;
  localparam logic [7:0] PadMark = 8'h80;
  localparam logic [2:0] LastIdx = 3'd7;

  localparam hash_t InitHash = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_UPDATE,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    PH_MARK,
    PH_ZERO,
    PH_LEN
  } pad_phase_t;

  // Control bundle from the sequencer to the schedule and round units.
  typedef struct packed {
    logic       push;       // shift one byte into the block window
    logic [7:0] push_byte;
    logic       init;       // load working variables from the chaining words
    logic       step;       // run one compression round
    logic [5:0] rnd;        // current round number
  } sha_ctl_t;

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t big_sigma0(input word_t x);
    big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t round_k(input logic [5:0] idx);
    unique case (idx)
      6'd0:  round_k = 32'h428a2f98;  6'd1:  round_k = 32'h71374491;
      6'd2:  round_k = 32'hb5c0fbcf;  6'd3:  round_k = 32'he9b5dba5;
      6'd4:  round_k = 32'h3956c25b;  6'd5:  round_k = 32'h59f111f1;
      6'd6:  round_k = 32'h923f82a4;  6'd7:  round_k = 32'hab1c5ed5;
      6'd8:  round_k = 32'hd807aa98;  6'd9:  round_k = 32'h12835b01;
      6'd10: round_k = 32'h243185be;  6'd11: round_k = 32'h550c7dc3;
      6'd12: round_k = 32'h72be5d74;  6'd13: round_k = 32'h80deb1fe;
      6'd14: round_k = 32'h9bdc06a7;  6'd15: round_k = 32'hc19bf174;
      6'd16: round_k = 32'he49b69c1;  6'd17: round_k = 32'hefbe4786;
      6'd18: round_k = 32'h0fc19dc6;  6'd19: round_k = 32'h240ca1cc;
      6'd20: round_k = 32'h2de92c6f;  6'd21: round_k = 32'h4a7484aa;
      6'd22: round_k = 32'h5cb0a9dc;  6'd23: round_k = 32'h76f988da;
      6'd24: round_k = 32'h983e5152;  6'd25: round_k = 32'ha831c66d;
      6'd26: round_k = 32'hb00327c8;  6'd27: round_k = 32'hbf597fc7;
      6'd28: round_k = 32'hc6e00bf3;  6'd29: round_k = 32'hd5a79147;
      6'd30: round_k = 32'h06ca6351;  6'd31: round_k = 32'h14292967;
      6'd32: round_k = 32'h27b70a85;  6'd33: round_k = 32'h2e1b2138;
      6'd34: round_k = 32'h4d2c6dfc;  6'd35: round_k = 32'h53380d13;
      6'd36: round_k = 32'h650a7354;  6'd37: round_k = 32'h766a0abb;
      6'd38: round_k = 32'h81c2c92e;  6'd39: round_k = 32'h92722c85;
      6'd40: round_k = 32'ha2bfe8a1;  6'd41: round_k = 32'ha81a664b;
      6'd42: round_k = 32'hc24b8b70;  6'd43: round_k = 32'hc76c51a3;
      6'd44: round_k = 32'hd192e819;  6'd45: round_k = 32'hd6990624;
      6'd46: round_k = 32'hf40e3585;  6'd47: round_k = 32'h106aa070;
      6'd48: round_k = 32'h19a4c116;  6'd49: round_k = 32'h1e376c08;
      6'd50: round_k = 32'h2748774c;  6'd51: round_k = 32'h34b0bcb5;
      6'd52: round_k = 32'h391c0cb3;  6'd53: round_k = 32'h4ed8aa4a;
      6'd54: round_k = 32'h5b9cca4f;  6'd55: round_k = 32'h682e6ff3;
      6'd56: round_k = 32'h748f82ee;  6'd57: round_k = 32'h78a5636f;
      6'd58: round_k = 32'h84c87814;  6'd59: round_k = 32'h8cc70208;
      6'd60: round_k = 32'h90befffa;  6'd61: round_k = 32'ha4506ceb;
      6'd62: round_k = 32'hbef9a3f7;  6'd63: round_k = 32'hc67178f2;
      default: round_k = 32'h0;
    endcase
  endfunction

endpackage

### rtl/sha_sched.sv
// Block window and rolling message schedule: bytes shift in, then words roll.
// Depends on sha_pkg.
module sha_sched (
  input  logic              clk,
  input  sha_pkg::sha_ctl_t ctl,
  output sha_pkg::word_t    wt
);
  import sha_pkg::*;

  word_t w_r [16];
  word_t w_new;

  assign w_new = w_r[0] + small_sigma0(w_r[1]) + w_r[9] + small_sigma1(w_r[14]);
  assign wt    = (ctl.rnd < SchedStart) ? w_r[0] : w_new;

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      for (int i = 0; i < 15; i++) begin
        w_r[i] <= {w_r[i][23:0], w_r[i+1][31:24]};
      end
      w_r[15] <= {w_r[15][23:0], ctl.push_byte};
    end else if (ctl.step) begin
      for (int i = 0; i < 15; i++) begin
        w_r[i] <= w_r[i+1];
      end
      w_r[15] <= wt;
    end
  end

endmodule

### rtl/sha_round.sv
// Working variables a to h and the single compression round unit.
// Depends on sha_pkg.
module sha_round (
  input  logic              clk,
  input  sha_pkg::sha_ctl_t ctl,
  input  sha_pkg::hash_t    h_in,
  input  sha_pkg::word_t    wt,
  output sha_pkg::hash_t    v_out
);
  import sha_pkg::*;

  hash_t v_r;
  word_t t1;
  word_t t2;
  word_t e;
  word_t a;

  assign e  = v_r[4];
  assign a  = v_r[0];
  assign t1 = v_r[7] + big_sigma1(e) + ((e & v_r[5]) ^ (~e & v_r[6]))
              + round_k(ctl.rnd) + wt;
  assign t2 = big_sigma0(a) + ((a & v_r[1]) ^ (a & v_r[2]) ^ (v_r[1] & v_r[2]));
  assign v_out = v_r;

  always_ff @(posedge clk) begin
    if (ctl.init) begin
      v_r <= h_in;
    end else if (ctl.step) begin
      v_r <= {v_r[6], v_r[5], v_r[4], v_r[3] + t1, v_r[2], v_r[1], v_r[0], t1 + t2};
    end
  end

endmodule

### rtl/sha256_stream_hasher.sv
// Top level of the SHA-256 stream hasher: sequencer, byte counter, padding
// and chaining words. Depends on sha_pkg, sha_sched and sha_round.
//
// Usage. The input channel carries one beat per request: req_type 0 appends
// data_byte to the message, req_type 1 finishes it. A finish produces eight
// result beats on the output channel, digest words 0 to 7 in order, with
// last_word set on the eighth; the block then starts a fresh message.
// Timing. The 64th byte of a block triggers compression: 64 rounds on one
// shared round unit at one round a cycle, then a fold of the result into
// the chaining words. A finish feeds the padding bytes one a cycle through
// the same byte path and compresses one or two blocks before the first
// digest beat appears.
// The input is not ready while padding, compressing or emitting.
// Reset (synchronous, active low) loads the initial hash values and clears
// the byte count. If the receiver stalls, the current digest word is held
// on the output ports and nothing else advances until it is taken.
module sha256_stream_hasher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);
  import sha_pkg::*;

  state_t     state_r, state_nxt;
  pad_phase_t phase_r, phase_nxt;
  logic [60:0] cnt_r;           // message length in bytes, wraps with bit count
  logic [63:0] len_r;           // bit length captured at finish, shifted out
  logic [5:0]  rnd_r;
  logic [2:0]  idx_r;
  logic        fin_r;
  hash_t       h_r;

  sha_ctl_t ctl;
  word_t    wt;
  hash_t    v;
  logic     in_acc;
  logic     out_acc;
  logic     len_byte;
  logic [5:0] pos;

  assign pos = cnt_r[5:0];

  // In the zero phase, reaching position 56 switches straight to the length bytes.
  assign len_byte = (state_r == ST_PAD) &&
                    ((phase_r == PH_LEN) || ((phase_r == PH_ZERO) && (pos == LenPos)));

  // Output decode.
  always_comb begin
    in_ready      = (state_r == ST_IDLE);
    out_valid     = (state_r == ST_OUT);
    ctl.push      = 1'b0;
    ctl.push_byte = in_data_byte;
    ctl.step      = (state_r == ST_ROUND);
    ctl.rnd       = rnd_r;
    unique case (state_r)
      ST_IDLE: begin
        ctl.push = in_valid && !in_req_type;
      end
      ST_PAD: begin
        ctl.push = 1'b1;
        if (phase_r == PH_MARK) begin
          ctl.push_byte = PadMark;
        end else if (len_byte) begin
          ctl.push_byte = len_r[63:56];
        end else begin
          ctl.push_byte = 8'h00;
        end
      end
      ST_ROUND, ST_UPDATE, ST_OUT: begin
        ctl.push = 1'b0;
      end
      default: begin
        ctl.push = 1'b0;
      end
    endcase
    ctl.init = ctl.push && (pos == LastPos);
  end

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && in_req_type) begin
          state_nxt = ST_PAD;
        end else if (in_acc && (pos == LastPos)) begin
          state_nxt = ST_ROUND;
        end
      end
      ST_PAD: begin
        if (pos == LastPos) begin
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (rnd_r == LastRound) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (!fin_r) begin
          state_nxt = ST_IDLE;
        end else if (phase_r == PH_LEN) begin
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_PAD;
        end
      end
      ST_OUT: begin
        if (out_acc && (idx_r == LastIdx)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Padding phase advance.
  always_comb begin
    phase_nxt = phase_r;
    if (in_acc && in_req_type) begin
      phase_nxt = PH_MARK;
    end else if (state_r == ST_PAD) begin
      if (phase_r == PH_MARK) begin
        phase_nxt = PH_ZERO;
      end else if (len_byte) begin
        phase_nxt = PH_LEN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= PH_MARK;
      cnt_r   <= '0;
      rnd_r   <= '0;
      idx_r   <= '0;
      fin_r   <= 1'b0;
      h_r     <= InitHash;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      if (ctl.push) begin
        cnt_r <= cnt_r + 61'd1;
      end
      if (in_acc && in_req_type) begin
        fin_r <= 1'b1;
      end
      if (state_r == ST_ROUND) begin
        rnd_r <= rnd_r + 6'd1;
      end else begin
        rnd_r <= '0;
      end
      if (state_r == ST_UPDATE) begin
        for (int i = 0; i < 8; i++) begin
          h_r[i] <= h_r[i] + v[i];
        end
      end else if (out_acc) begin
        if (idx_r == LastIdx) begin
          // Digest delivered: back to the start of a new message.
          h_r   <= InitHash;
          cnt_r <= '0;
          fin_r <= 1'b0;
          idx_r <= '0;
        end else begin
          h_r   <= {h_r[0], h_r[7:1]};
          idx_r <= idx_r + 3'd1;
        end
      end
    end
  end

  // Length register: captured at finish, then shifted a byte per length beat.
  always_ff @(posedge clk) begin
    if (in_acc && in_req_type) begin
      len_r <= {cnt_r, 3'b000};
    end else if (len_byte) begin
      len_r <= {len_r[55:0], 8'h00};
    end
  end

  assign out_digest_word = h_r[0];
  assign out_word_index  = idx_r;
  assign out_last_word   = (idx_r == LastIdx);

  sha_sched u_sched (
    .clk (clk),
    .ctl (ctl),
    .wt  (wt)
  );

  sha_round u_round (
    .clk   (clk),
    .ctl   (ctl),
    .h_in  (h_r),
    .wt    (wt),
    .v_out (v)
  );

endmodule
